[hw/rtl/fuzzy_dynamic_task_priority_assert.svh]
// Assertion macros shared by the dynamic task priority scorer.
`ifndef FUZZY_DYNAMIC_TASK_PRIORITY_ASSERT_SVH
`define FUZZY_DYNAMIC_TASK_PRIORITY_ASSERT_SVH

// Checks a property on every rising clock edge outside of reset.
`define FDTP_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("fdtp assertion failed");

// Checks that a consequent follows whenever an antecedent holds.
`define FDTP_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fdtp implication failed");

`endif

[hw/rtl/fdtp_pkg.sv]
// Package with the types, constants and lookup functions of the priority scorer.
`timescale 1ns / 1ps

package fdtp_pkg;

	// Number of base priority levels; the base term is level * 1.0 / PRIORITY_LEVELS.
	localparam int PRIORITY_LEVELS = 256;

	// Base term width and the reciprocal that turns the division into a multiply.
	localparam int BASE_W = 24 - $clog2(PRIORITY_LEVELS);
	localparam logic [31:0] BASE_RECIP = 32'(((64'd1 << 31) + 64'(PRIORITY_LEVELS) - 64'd1)
		/ 64'(PRIORITY_LEVELS));

	// Signed widths of the raw score and of the scaled product.
	localparam int SCORE_W = ((BASE_W > 17) ? BASE_W : 17) + 2;
	localparam int PROD_W = SCORE_W + 17;

	// Weighted membership sum and its reciprocal of ten (exact for sums below 2^22).
	localparam int WSUM_W = 19;
	localparam logic [20:0] DIV10_RECIP = 21'd1677722;
	localparam int DIV10_SHIFT = 24;

	// Register indexes of the configuration port.
	localparam logic [1:0] REG_POWER_LIMIT = 2'd0;
	localparam logic [1:0] REG_TEMP_LIMIT = 2'd1;
	localparam logic [1:0] REG_POWER_PENALTY = 2'd2;
	localparam logic [1:0] REG_TEMP_PENALTY = 2'd3;

	// Register reset values.
	localparam logic [15:0] POWER_LIMIT_RST = 16'd16384;
	localparam logic signed [15:0] TEMP_LIMIT_RST = 16'sd17920;
	localparam logic [15:0] POWER_PENALTY_RST = 16'd6554;
	localparam logic [15:0] TEMP_PENALTY_RST = 16'd4915;

	// Criticality class codes.
	localparam logic [2:0] CRIT_A = 3'd0;
	localparam logic [2:0] CRIT_B = 3'd1;
	localparam logic [2:0] CRIT_C = 3'd2;
	localparam logic [2:0] CRIT_D = 3'd3;

	// Membership table in Q1.15, rows are levels, columns are criticality columns.
	localparam logic [15:0] MEMBER_TAB [5][5] = '{
		'{16'd32768, 16'd22938, 16'd9830, 16'd3277, 16'd0},
		'{16'd22938, 16'd32768, 16'd22938, 16'd9830, 16'd3277},
		'{16'd9830, 16'd22938, 16'd32768, 16'd22938, 16'd9830},
		'{16'd3277, 16'd9830, 16'd22938, 16'd32768, 16'd22938},
		'{16'd0, 16'd3277, 16'd9830, 16'd22938, 16'd32768}
	};

	typedef logic [2:0] level_t;

	typedef struct packed {
		logic [7:0] base_level;
		logic [2:0] crit_class;
		logic [15:0] urgency;
		logic [15:0] fault_factor;
		logic [15:0] cpu_load;
		logic signed [15:0] temperature;
		logic [15:0] power_draw;
	} req_t;

	typedef struct packed {
		logic [15:0] priority_res;
		logic saturated;
	} res_t;

	typedef struct packed {
		logic [15:0] power_limit;
		logic signed [15:0] temp_limit;
		logic [15:0] power_penalty;
		logic [15:0] temp_penalty;
	} cfg_t;

	// Front end to scaler hand-off.
	typedef struct packed {
		logic valid;
		logic signed [SCORE_W-1:0] score;
		logic [WSUM_W-1:0] wsum;
	} front_t;

	function automatic level_t crit_column(input logic [2:0] crit);
		level_t col;
		unique case (crit)
			CRIT_A: col = 3'd0;
			CRIT_B: col = 3'd1;
			CRIT_C: col = 3'd3;
			CRIT_D: col = 3'd4;
			default: col = 3'd2;
		endcase
		return col;
	endfunction

	function automatic level_t load_level(input logic [15:0] load);
		level_t lvl;
		lvl = (load[15:13] > 3'd4) ? 3'd4 : load[15:13];
		return lvl;
	endfunction

	// Steps of 3840 above 20 C, saturating at 80 C.
	function automatic level_t temp_level(input logic signed [15:0] t);
		level_t lvl;
		lvl = 3'(t >= 16'sd8960) + 3'(t >= 16'sd12800) + 3'(t >= 16'sd16640)
			+ 3'(t >= 16'sd20480);
		return lvl;
	endfunction

	// Steps of 4608 above 0.5 W, saturating at 5.0 W.
	function automatic level_t power_level(input logic [15:0] p);
		level_t lvl;
		lvl = 3'(p >= 16'd6656) + 3'(p >= 16'd11264) + 3'(p >= 16'd15872)
			+ 3'(p >= 16'd20480);
		return lvl;
	endfunction

endpackage

[hw/rtl/fuzzy_dynamic_task_priority.sv]
// Top level of the fuzzy dynamic task priority scorer.
`timescale 1ns / 1ps

// The scorer takes one request transaction in every clock cycle and returns
// the results in request order at the end of its pipeline; busy is never
// raised, so start may be held high continuously. The design has five
// pipeline stages, each closed by a register: the urgency and base-level
// multiplies, the score adder and membership sum, the divide-by-ten multiply,
// the score-by-factor multiply and the output clamp. Each result appears on
// result for exactly one cycle with done high and cannot be held off, so
// the receiver must take every result in the cycle it is shown. The
// configuration registers are written through cfg_we, cfg_idx and cfg_wdata
// and take effect for requests started after the write; write them only
// while no request is in flight. The block holds no state across requests
// besides those registers.

`include "fuzzy_dynamic_task_priority_assert.svh"

module fuzzy_dynamic_task_priority (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  fdtp_pkg::req_t     request,
	output logic               done,
	output fdtp_pkg::res_t     result,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_idx,
	input  logic [15:0]        cfg_wdata
);

	fdtp_pkg::cfg_t   cfg;
	fdtp_pkg::front_t front;
	logic             take;

	// The pipeline never stalls, so requests are always welcome.
	assign busy = 1'b0;
	assign take = start && !busy;

	fdtp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	fdtp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.req    (request),
		.cfg    (cfg),
		.front  (front)
	);

	fdtp_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.front  (front),
		.done   (done),
		.result (result)
	);

	// Every accepted request produces its result.
	`FDTP_ASSERT_IMPL(a_latency, take, ##5 done)
	// No result appears without a matching accepted request.
	`FDTP_ASSERT_IMPL(a_no_phantom, done, $past(take, 5))
	// An unclamped result stays within one; a clamped one sits at a bound.
	`FDTP_ASSERT_IMPL(a_range, done, (result.saturated ? (result.priority_res == 16'd0
		|| result.priority_res == 16'd32768) : (result.priority_res <= 16'd32768)))
	// The scaler stage sees data once the request has passed the stage 1 and stage 2 registers.
	`FDTP_ASSERT_IMPL(a_front_valid, take, ##2 front.valid)

endmodule

[hw/rtl/fdtp_cfg.sv]
// Configuration registers of the priority scorer.
`timescale 1ns / 1ps

module fdtp_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_idx,
	input  logic [15:0]        cfg_wdata,
	output fdtp_pkg::cfg_t     cfg
);

	fdtp_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.power_limit <= fdtp_pkg::POWER_LIMIT_RST;
			cfg_q.temp_limit <= fdtp_pkg::TEMP_LIMIT_RST;
			cfg_q.power_penalty <= fdtp_pkg::POWER_PENALTY_RST;
			cfg_q.temp_penalty <= fdtp_pkg::TEMP_PENALTY_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				fdtp_pkg::REG_POWER_LIMIT: cfg_q.power_limit <= cfg_wdata;
				fdtp_pkg::REG_TEMP_LIMIT: cfg_q.temp_limit <= $signed(cfg_wdata);
				fdtp_pkg::REG_POWER_PENALTY: cfg_q.power_penalty <= cfg_wdata;
				fdtp_pkg::REG_TEMP_PENALTY: cfg_q.temp_penalty <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[hw/rtl/fdtp_front.sv]
// Front end: products, penalty and levels, then raw score and weighted membership sum.
`timescale 1ns / 1ps

module fdtp_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  fdtp_pkg::req_t     req,
	input  fdtp_pkg::cfg_t     cfg,
	output fdtp_pkg::front_t   front
);

	// Stage 1 registers.
	logic                            valid_s1;
	logic [fdtp_pkg::BASE_W-1:0]     base_term_s1;
	logic [31:0]                     urg_prod_s1;
	logic [15:0]                     penalty_s1;
	fdtp_pkg::level_t                lvl_l_s1;
	fdtp_pkg::level_t                lvl_t_s1;
	fdtp_pkg::level_t                lvl_p_s1;
	fdtp_pkg::level_t                col_s1;

	// Stage 2 registers.
	logic                              valid_s2;
	logic signed [fdtp_pkg::SCORE_W-1:0] score_s2;
	logic [fdtp_pkg::WSUM_W-1:0]       wsum_s2;

	logic [39:0] base_prod;
	logic [15:0] penalty;
	logic signed [fdtp_pkg::SCORE_W-1:0] score;
	logic [15:0] m_l;
	logic [15:0] m_t;
	logic [15:0] m_p;
	logic [fdtp_pkg::WSUM_W-1:0] wsum;

	assign base_prod = {32'd0, req.base_level} * {8'd0, fdtp_pkg::BASE_RECIP};

	// Power over its limit wins over temperature over its limit.
	always_comb begin
		if (req.power_draw > cfg.power_limit) begin
			penalty = cfg.power_penalty;
		end else if (req.temperature > cfg.temp_limit) begin
			penalty = cfg.temp_penalty;
		end else begin
			penalty = 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		base_term_s1 <= base_prod[16 +: fdtp_pkg::BASE_W];
		urg_prod_s1 <= req.urgency * req.fault_factor;
		penalty_s1 <= penalty;
		lvl_l_s1 <= fdtp_pkg::load_level(req.cpu_load);
		lvl_t_s1 <= fdtp_pkg::temp_level(req.temperature);
		lvl_p_s1 <= fdtp_pkg::power_level(req.power_draw);
		col_s1 <= fdtp_pkg::crit_column(req.crit_class);
	end

	assign score = $signed({{(fdtp_pkg::SCORE_W - fdtp_pkg::BASE_W){1'b0}}, base_term_s1})
		+ $signed({{(fdtp_pkg::SCORE_W - 17){1'b0}}, urg_prod_s1[31:15]})
		- $signed({{(fdtp_pkg::SCORE_W - 16){1'b0}}, penalty_s1});

	assign m_l = fdtp_pkg::MEMBER_TAB[lvl_l_s1][col_s1];
	assign m_t = fdtp_pkg::MEMBER_TAB[lvl_t_s1][col_s1];
	assign m_p = fdtp_pkg::MEMBER_TAB[lvl_p_s1][col_s1];

	// Weights 0.5, 0.3 and 0.2 scaled by ten, plus five for rounding.
	assign wsum = 19'd5 * {3'd0, m_l} + 19'd3 * {3'd0, m_t} + 19'd2 * {3'd0, m_p} + 19'd5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		score_s2 <= score;
		wsum_s2 <= wsum;
	end

	assign front.valid = valid_s2;
	assign front.score = score_s2;
	assign front.wsum = wsum_s2;

endmodule

[hw/rtl/fdtp_scale.sv]
// Back end: fuzzy factor by reciprocal of ten, score times factor, then clamp.
`timescale 1ns / 1ps

module fdtp_scale (
	input  logic               clk,
	input  logic               arst_n,
	input  fdtp_pkg::front_t   front,
	output logic               done,
	output fdtp_pkg::res_t     result
);

	localparam logic signed [fdtp_pkg::PROD_W-1:0] PROD_ONE =
		fdtp_pkg::PROD_W'(1073741824);

	logic                                valid_s3;
	logic [15:0]                         factor_s3;
	logic signed [fdtp_pkg::SCORE_W-1:0] score_s3;

	logic                                valid_s4;
	logic signed [fdtp_pkg::PROD_W-1:0]  prod_s4;

	logic                                valid_s5;
	fdtp_pkg::res_t                      result_s5;

	logic [39:0]    div_prod;
	fdtp_pkg::res_t clamped;

	assign div_prod = {21'd0, front.wsum} * {19'd0, fdtp_pkg::DIV10_RECIP};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s3 <= front.valid;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// Both operands are sign-extended to the full product width first, so the
	// multiply keeps every bit of the score-by-factor product.
	always_ff @(posedge clk) begin
		factor_s3 <= div_prod[fdtp_pkg::DIV10_SHIFT +: 16];
		score_s3 <= front.score;
		prod_s4 <= fdtp_pkg::PROD_W'(score_s3)
			* fdtp_pkg::PROD_W'($signed({1'b0, factor_s3}));
		result_s5 <= clamped;
	end

	// A zero factor on a negative score gives zero without saturation.
	always_comb begin
		if (prod_s4 < 0) begin
			clamped.priority_res = 16'd0;
			clamped.saturated = 1'b1;
		end else if (prod_s4 > PROD_ONE) begin
			clamped.priority_res = 16'd32768;
			clamped.saturated = 1'b1;
		end else begin
			clamped.priority_res = prod_s4[30:15];
			clamped.saturated = 1'b0;
		end
	end

	assign done = valid_s5;
	assign result = result_s5;

endmodule
